FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the deadline timer queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge of clk, quiet while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

FILE: hw/rtl/dtq_pkg.sv
// Types, constants and codes for the deadline timer queue.
`default_nettype none

package dtq_pkg;

	localparam int DTQ_DEPTH   = 16;
	localparam int DTQ_MAX_RUN = 16;
	localparam int DTQ_RUN_W   = $clog2(DTQ_MAX_RUN);
	localparam int DTQ_TIME_W  = 32;
	localparam int DTQ_ID_W    = 16;
	localparam int DTQ_DELAY_W = 16;

	// Request types
	localparam logic REQ_SCHED = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	// Result kinds
	localparam logic KIND_STATUS  = 1'b0;
	localparam logic KIND_EXPIRED = 1'b1;

	// Schedule status codes
	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_FULL = 1'b1;

	// One queue entry
	typedef struct packed {
		logic                  valid;
		logic [DTQ_TIME_W-1:0] deadline;
		logic [DTQ_ID_W-1:0]   handle;
	} slot_t;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic                  ins;
		logic                  pop;
		logic [DTQ_TIME_W-1:0] new_deadline;
		logic [DTQ_ID_W-1:0]   new_handle;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dtq_cell.sv
// One cell of the sorted deadline chain: holds one entry, shifts on insert and pop.
`default_nettype none

module dtq_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  dtq_pkg::cell_ctrl_t ctrl,
	input  dtq_pkg::slot_t      left,
	input  wire                 left_gt,
	input  dtq_pkg::slot_t      right,
	output dtq_pkg::slot_t      slot,
	output logic                gt
);
	import dtq_pkg::*;

	logic                  valid_q;
	logic [DTQ_TIME_W-1:0] deadline_q;
	logic [DTQ_ID_W-1:0]   handle_q;
	slot_t                 slot_nxt;
	logic [DTQ_TIME_W-1:0] diff;

	// Flag an entry that must move behind the new request: empty, or strictly later.
	// Equal deadlines stay ahead so older entries leave first.
	assign diff = ctrl.new_deadline - deadline_q;
	assign gt   = !valid_q || diff[DTQ_TIME_W-1];

	// Pick the next content: pull from the right on pop, shift or take the new entry on insert
	always_comb begin
		slot_nxt = slot;
		if (ctrl.pop) begin
			slot_nxt = right;
		end else if (ctrl.ins && gt) begin
			if (left_gt) begin
				slot_nxt = left;
			end else begin
				slot_nxt.valid    = 1'b1;
				slot_nxt.deadline = ctrl.new_deadline;
				slot_nxt.handle   = ctrl.new_handle;
			end
		end
	end

	// Hold the valid flag under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= slot_nxt.valid;
		end
	end

	// Hold the payload
	always_ff @(posedge clk) begin
		deadline_q <= slot_nxt.deadline;
		handle_q   <= slot_nxt.handle;
	end

	assign slot = {valid_q, deadline_q, handle_q};

endmodule

`default_nettype wire

FILE: hw/rtl/deadline_timer_queue.sv
// Top level of the deadline timer queue: request control, time counter and cell chain.
`default_nettype none
`include "assert_macros.svh"

// A request is taken when start is high and busy is low. A schedule request stores
// handle_id with deadline now + delay_ticks in a chain of DEPTH cells kept sorted by
// deadline (equal deadlines in arrival order) unless the chain is full, and answers
// one status result; the request is registered, then the chain shifts it into place.
// A tick request advances the time counter and then emits the expired handles earliest
// first, one per cycle from the head cell, at most 16 per tick, the last one marked by
// last_of_run, and gives no result when nothing has expired. Each result is shown for
// one cycle with result_strobe high and the receiver cannot stall it; a result appears
// in the cycle after the step that makes it, and busy may already be low in that cycle.
module deadline_timer_queue #(
	parameter int DEPTH = dtq_pkg::DTQ_DEPTH
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire                          req_type,
	input  wire  [dtq_pkg::DTQ_ID_W-1:0]    handle_id,
	input  wire  [dtq_pkg::DTQ_DELAY_W-1:0] delay_ticks,
	output logic                         result_strobe,
	output logic                         result_kind,
	output logic [dtq_pkg::DTQ_ID_W-1:0] expired_id,
	output logic                         sched_status,
	output logic                         last_of_run
);
	import dtq_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_INS  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic [DTQ_TIME_W-1:0] now_q;
	logic [DTQ_RUN_W-1:0]  count_q;
	logic [DTQ_TIME_W-1:0] new_deadline_q;
	logic [DTQ_ID_W-1:0]   new_handle_q;

	logic                  strobe_q;
	logic                  kind_q;
	logic [DTQ_ID_W-1:0]   id_q;
	logic                  status_q;
	logic                  last_q;

	slot_t                 slot_w [DEPTH];
	logic                  gt_w   [DEPTH];
	logic [DEPTH-1:0]      vld;
	cell_ctrl_t            ctrl;

	logic                  accept;
	logic                  full;
	logic [DTQ_TIME_W-1:0] age0;
	logic [DTQ_TIME_W-1:0] age1;
	logic                  head_exp;
	logic                  next_exp;
	logic                  emit;
	logic                  emit_last;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// Gather the valid flags of the chain
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			vld[i] = slot_w[i].valid;
		end
	end
	assign full = vld[DEPTH-1];

	// Check the head and the entry behind it against the current time
	assign age0      = now_q - slot_w[0].deadline;
	assign age1      = now_q - slot_w[1].deadline;
	assign head_exp  = slot_w[0].valid && !age0[DTQ_TIME_W-1];
	assign next_exp  = slot_w[1].valid && !age1[DTQ_TIME_W-1];
	assign emit      = (state_q == ST_EMIT) && head_exp;
	assign emit_last = (count_q == DTQ_RUN_W'(DTQ_MAX_RUN - 1)) || !next_exp;

	// Drive the chain command
	assign ctrl.ins          = (state_q == ST_INS) && !full;
	assign ctrl.pop          = emit;
	assign ctrl.new_deadline = new_deadline_q;
	assign ctrl.new_handle   = new_handle_q;

	// Build the chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		slot_t left_s;
		slot_t right_s;
		logic  left_gt_s;
		if (i == 0) begin : g_head
			assign left_s    = '0;
			assign left_gt_s = 1'b0;
		end else begin : g_body
			assign left_s    = slot_w[i-1];
			assign left_gt_s = gt_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_s = '0;
		end else begin : g_inner
			assign right_s = slot_w[i+1];
		end
		dtq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.left    (left_s),
			.left_gt (left_gt_s),
			.right   (right_s),
			.slot    (slot_w[i]),
			.gt      (gt_w[i])
		);
	end

	// Sequence requests, advance time and count the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q   <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == REQ_TICK) begin
							now_q   <= now_q + 1'b1;
							count_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_INS;
						end
					end
				end
				ST_INS: begin
					state_q <= ST_IDLE;
				end
				ST_EMIT: begin
					if (emit) begin
						count_q <= count_q + 1'b1;
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the schedule request
	always_ff @(posedge clk) begin
		if (accept) begin
			new_deadline_q <= now_q + DTQ_TIME_W'(delay_ticks);
			new_handle_q   <= handle_id;
		end
	end

	// Raise the result strobe for one cycle with each result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_INS) || emit;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_INS) begin
			kind_q   <= KIND_STATUS;
			id_q     <= '0;
			status_q <= full ? STAT_FULL : STAT_OK;
			last_q   <= 1'b1;
		end else if (emit) begin
			kind_q   <= KIND_EXPIRED;
			id_q     <= slot_w[0].handle;
			status_q <= STAT_OK;
			last_q   <= emit_last;
		end
	end

	assign result_strobe = strobe_q;
	assign result_kind   = kind_q;
	assign expired_id    = id_q;
	assign sched_status  = status_q;
	assign last_of_run   = last_q;

	// Results only follow a cycle of work
	`ASSERT_CLK(a_strobe_after_work, strobe_q |-> ($past(state_q) != ST_IDLE), "result without a working cycle")
	// The marked emission ends the run
	`ASSERT_CLK(a_last_ends_run, (emit && emit_last) |=> (state_q == ST_IDLE), "run did not end after last handle")
	// An unmarked expired result means the run goes on
	`ASSERT_CLK(a_run_continues, (strobe_q && kind_q == KIND_EXPIRED && !last_q) |-> (state_q == ST_EMIT), "run stopped before its last handle")
	// Entries stay packed from the head of the chain
	`ASSERT_NEVER(a_chain_packed, ((vld + 1'b1) & vld) != '0, "hole in the cell chain")

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the deadline timer queue: directed and random requests.
`default_nettype none

module tb_top;
	import dtq_pkg::*;

	localparam int STALL_LIMIT  = 3000;
	localparam int RANDOM_ITEMS = 82;
	localparam int MAX_REPORTS  = 10;
	localparam int SETTLE       = 40;

	typedef struct {
		logic                kind;
		logic [DTQ_ID_W-1:0] id;
		logic                status;
		logic                last;
	} outcome_t;

	// Track pending handles by deadline and hold the results they are due to produce
	class expiry_tracker;
		logic [DTQ_TIME_W-1:0] clock_now;
		logic [DTQ_TIME_W-1:0] pend_deadline[DTQ_DEPTH];
		logic [DTQ_ID_W-1:0]   pend_handle[DTQ_DEPTH];
		int                    pend_count;
		outcome_t              due_results[$];
		int                    mismatches;
		int                    checked;
		int                    requests;
		int                    ticks;
		int                    drops;
		int                    longest_run;

		function new();
			clock_now   = '0;
			pend_count  = 0;
			mismatches  = 0;
			checked     = 0;
			requests    = 0;
			ticks       = 0;
			drops       = 0;
			longest_run = 0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// Predict the results of one accepted request
		function void note_request(logic rt, logic [DTQ_ID_W-1:0] id,
				logic [DTQ_DELAY_W-1:0] dly);
			outcome_t              o;
			logic [DTQ_TIME_W-1:0] age;
			logic [DTQ_TIME_W-1:0] best_age;
			int                    best;
			int                    run;
			requests++;
			if (rt == REQ_SCHED) begin
				o.kind = KIND_STATUS;
				o.id   = '0;
				o.last = 1'b1;
				if (pend_count >= DTQ_DEPTH) begin
					o.status = STAT_FULL;
					drops++;
				end else begin
					o.status = STAT_OK;
					pend_deadline[pend_count] = clock_now + {{(DTQ_TIME_W-DTQ_DELAY_W){1'b0}}, dly};
					pend_handle[pend_count]   = id;
					pend_count++;
				end
				due_results.push_back(o);
				return;
			end
			// Advance time, then pull the oldest expired handle until none is left or the run reaches DTQ_MAX_RUN
			ticks++;
			clock_now = clock_now + 1;
			run = 0;
			while (run < DTQ_MAX_RUN) begin
				best     = -1;
				best_age = '0;
				for (int i = 0; i < pend_count; i++) begin
					age = clock_now - pend_deadline[i];
					if (!age[DTQ_TIME_W-1] && (best < 0 || age > best_age)) begin
						best     = i;
						best_age = age;
					end
				end
				if (best < 0)
					break;
				o.kind   = KIND_EXPIRED;
				o.id     = pend_handle[best];
				o.status = STAT_OK;
				o.last   = 1'b0;
				due_results.push_back(o);
				for (int i = best; i + 1 < pend_count; i++) begin
					pend_deadline[i] = pend_deadline[i+1];
					pend_handle[i]   = pend_handle[i+1];
				end
				pend_count--;
				run++;
			end
			// Mark the final handle of this tick
			if (run > 0) begin
				o = due_results.pop_back();
				o.last = 1'b1;
				due_results.push_back(o);
			end
			if (run > longest_run)
				longest_run = run;
		endfunction

		// Compare one result with the oldest one due
		function void check_result(logic kind, logic [DTQ_ID_W-1:0] id, logic status,
				logic last);
			outcome_t want;
			checked++;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: kind=%0d id=%h status=%0d last=%0d",
						kind, id, status, last);
				return;
			end
			want = due_results.pop_front();
			if (kind !== want.kind || id !== want.id || status !== want.status ||
					last !== want.last) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result mismatch: expected kind=%0d id=%h status=%0d last=%0d, got kind=%0d id=%h status=%0d last=%0d",
						want.kind, want.id, want.status, want.last,
						kind, id, status, last);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic                   req_type;
	logic [DTQ_ID_W-1:0]    handle_id;
	logic [DTQ_DELAY_W-1:0] delay_ticks;
	logic                   result_strobe;
	logic                   result_kind;
	logic [DTQ_ID_W-1:0]    expired_id;
	logic                   sched_status;
	logic                   last_of_run;

	expiry_tracker tracker = new();
	int            stall_cycles = 0;

	deadline_timer_queue #(
		.DEPTH(DTQ_DEPTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.handle_id    (handle_id),
		.delay_ticks  (delay_ticks),
		.result_strobe(result_strobe),
		.result_kind  (result_kind),
		.expired_id   (expired_id),
		.sched_status (sched_status),
		.last_of_run  (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Sample requests and results at the rising edge, and count cycles without progress
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_strobe)
				tracker.check_result(result_kind, expired_id, sched_status, last_of_run);
			if (start && !busy)
				tracker.note_request(req_type, handle_id, delay_ticks);
			if (result_strobe || (start && !busy))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	// Abort when the block stops making progress
	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
		$display("tb_top NOT OK");
		$finish;
	end

	// Present one request and hold it until the block takes it
	task automatic send_request(input logic rt, input logic [DTQ_ID_W-1:0] id,
			input logic [DTQ_DELAY_W-1:0] dly);
		start       = 1'b1;
		req_type    = rt;
		handle_id   = id;
		delay_ticks = dly;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop start for a number of cycles, with noise on the fields
	task automatic idle_gap(input int cycles);
		if (cycles > 0) begin
			start = 1'b0;
			repeat (cycles) begin
				req_type    = 1'($urandom);
				handle_id   = 16'($urandom);
				delay_ticks = 16'($urandom);
				@(negedge clk);
			end
		end
	endtask

	// Hold off until every due result has come and the block is idle
	task automatic drain_queue();
		start = 1'b0;
		while (tracker.pending() != 0 || busy)
			@(negedge clk);
	endtask

	initial begin
		int                     items;
		int                     burst;
		int                     pick;
		logic [DTQ_DELAY_W-1:0] dly;
		start       = 1'b0;
		req_type    = REQ_SCHED;
		handle_id   = '0;
		delay_ticks = '0;
		arst_n      = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fill the queue with zero delays, overflow it, then expire all in one tick
		for (int i = 0; i < DTQ_DEPTH; i++)
			send_request(REQ_SCHED, (i == DTQ_DEPTH - 1) ? 16'hFFFF : 16'(i), 16'h0000);
		send_request(REQ_SCHED, 16'hABCD, 16'h0000);
		send_request(REQ_TICK, 16'hFFFF, 16'hFFFF);
		idle_gap(3);
		// Tick with nothing expired
		send_request(REQ_TICK, 16'h0000, 16'h0000);
		// Longest delay, equal deadlines, and a zero delay
		send_request(REQ_SCHED, 16'hFFFF, 16'hFFFF);
		send_request(REQ_SCHED, 16'h1001, 16'h0002);
		send_request(REQ_SCHED, 16'h1002, 16'h0002);
		send_request(REQ_SCHED, 16'h1003, 16'h0001);
		send_request(REQ_SCHED, 16'h0000, 16'h0000);
		repeat (4)
			send_request(REQ_TICK, 16'($urandom), 16'($urandom));
		drain_queue();

		// Random bursts, mostly short delays so handles keep expiring
		items = 0;
		while (items < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 8);
			for (int b = 0; b < burst && items < RANDOM_ITEMS; b++) begin
				if ($urandom_range(0, 99) < 55) begin
					pick = $urandom_range(0, 99);
					if (pick < 70)
						dly = 16'($urandom_range(0, 6));
					else if (pick < 95)
						dly = 16'($urandom_range(0, 40));
					else
						dly = 16'($urandom);
					send_request(REQ_SCHED, 16'($urandom), dly);
				end else begin
					send_request(REQ_TICK, 16'($urandom), 16'($urandom));
				end
				items++;
				if (items == RANDOM_ITEMS / 2)
					drain_queue();
			end
			if ($urandom_range(0, 3) == 0)
				idle_gap(0);
			else
				idle_gap($urandom_range(1, 12));
		end

		// Let everything settle, then watch for stray results
		drain_queue();
		repeat (SETTLE) @(negedge clk);

		$display("covered %0d requests (%0d ticks), %0d results checked, %0d dropped as full",
			tracker.requests, tracker.ticks, tracker.checked, tracker.drops);
		$display("longest expiry run %0d, mismatches %0d, results still due %0d",
			tracker.longest_run, tracker.mismatches, tracker.pending());
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
